[rtl/core/mpfd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and field widths of the monochrome page frame buffer writer.
package mpfd_pkg;

    // Default geometry of the frame store.
    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;

    // Field widths.
    localparam int KIND_W    = 3;
    localparam int COORD_W   = 8;
    localparam int COUNT_W   = 14;
    localparam int BIDX_W    = 10;
    localparam int DATA_W    = 8;
    localparam int UCNT_W    = 16;
    localparam int PW_W      = 8;
    localparam int PH_W      = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Effective panel width holds up to 256, effective height up to 128.
    localparam int WID_W = 9;
    localparam int HGT_W = 8;

    // Width of the page-times-width-plus-column product.
    localparam int MUL_W = 15;

    // Register reset values.
    localparam logic [PW_W-1:0] RESET_PANEL_WIDTH  = PW_W'(128);
    localparam logic [PH_W-1:0] RESET_PANEL_HEIGHT = PH_W'(64);

    // Command codes.
    localparam logic [KIND_W-1:0] KIND_SET_WINDOW = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_START  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FILL_COUNT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FILL_RECT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PIXEL      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;

endpackage

[rtl/core/mpfd_ram.sv]
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/mono_page_framebuffer_draw.sv]
`timescale 1ns / 1ps
// Top level of the monochrome page-layout frame buffer writer.
//
//  Channel   Handshake                Payload
//  -------   ---------------------    ------------------------------------------------
//  command   start / busy             kind, pos_x, pos_y, span_w, span_h, colour,
//                                     pixel_count, byte_index
//  result    done (one-cycle strobe)  read_data, update_count
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A command transaction is taken at an edge with start high and busy low. Window commands,
// unused codes and commands that draw nothing answer in the next cycle, a read
// via S_RDWAIT. Each pixel drawn by a fill, rectangle or pixel command passes address
// multiply, store read, read-modify-write and cursor step; off-panel fill positions skip
// to the cursor step. After reset a clearing pass zeroes one byte a cycle with busy high.
// The receiver cannot stall the one-cycle result; configuration writes are always ready.
module mono_page_framebuffer_draw #(
    parameter int MAX_COLUMNS = mpfd_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = mpfd_pkg::DEF_MAX_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Command transaction.
    input  logic                           start,
    output logic                           busy,
    input  logic [mpfd_pkg::KIND_W-1:0]    kind,
    input  logic [mpfd_pkg::COORD_W-1:0]   pos_x,
    input  logic [mpfd_pkg::COORD_W-1:0]   pos_y,
    input  logic [mpfd_pkg::COORD_W-1:0]   span_w,
    input  logic [mpfd_pkg::COORD_W-1:0]   span_h,
    input  logic                           colour,
    input  logic [mpfd_pkg::COUNT_W-1:0]   pixel_count,
    input  logic [mpfd_pkg::BIDX_W-1:0]    byte_index,
    // Result transaction.
    output logic                           done,
    output logic [mpfd_pkg::DATA_W-1:0]    read_data,
    output logic [mpfd_pkg::UCNT_W-1:0]    update_count,
    // Configuration transaction.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpfd_pkg::CFG_DAT_W-1:0] cfg_data
);

    import mpfd_pkg::*;

    // Store geometry. Every pixel inside the clamped panel maps below DEPTH.
    localparam int DEPTH   = MAX_COLUMNS * (MAX_ROWS / 8);
    localparam int AW      = $clog2(DEPTH);
    localparam int CMP_W   = ((AW > BIDX_W) ? AW : BIDX_W) + 1;
    localparam logic [WID_W-1:0] MAX_W   = WID_W'(MAX_COLUMNS);
    localparam logic [HGT_W-1:0] ROW_TOP = HGT_W'((MAX_ROWS / 8) * 8);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

    // The sequencer: one-hot states.
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_RDWAIT = 7'b0000100,
        S_ADDR   = 7'b0001000,
        S_READ   = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_STEP   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [PW_W-1:0]      width_reg, width_next;
    logic [PH_W-1:0]      height_reg, height_next;
    logic [COORD_W-1:0]   win_left_reg, win_left_next;
    logic [COORD_W-1:0]   win_top_reg, win_top_next;
    logic [COORD_W-1:0]   win_right_reg, win_right_next;
    logic [COORD_W-1:0]   win_bottom_reg, win_bottom_next;
    logic [COORD_W-1:0]   cur_col_reg, cur_col_next;
    logic [COORD_W-1:0]   cur_row_reg, cur_row_next;
    logic [UCNT_W-1:0]    draw_cnt_reg, draw_cnt_next;
    logic                 done_reg, done_next;
    logic [DATA_W-1:0]    rd_out_reg, rd_out_next;
    logic [AW-1:0]        addr_reg, addr_next;

    // Per-command working registers; no reset needed.
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic                 colour_reg, colour_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COORD_W-1:0]   wcol_reg, wcol_next;
    logic [COORD_W-1:0]   wrow_reg, wrow_next;
    logic [COORD_W-1:0]   rx0_reg, rx0_next;
    logic [WID_W-1:0]     rex_reg, rex_next;
    logic [WID_W-1:0]     rey_reg, rey_next;
    logic [2:0]           bit_reg, bit_next;
    logic                 rd_ok_reg, rd_ok_next;

    // Frame store port signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DATA_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [DATA_W-1:0]    ram_rdata;

    // Derived values.
    logic [WID_W-1:0]     w_eff;
    logic [HGT_W-1:0]     h_eff;
    logic [HGT_W-1:0]     h_floor;
    logic [CMP_W-1:0]     bidx_ext;
    logic [COORD_W-1:0]   pcol;
    logic [COORD_W-1:0]   prow;
    logic                 in_panel;
    logic [MUL_W-1:0]     idx_full;
    logic [DATA_W-1:0]    bit_mask;
    logic [WID_W-1:0]     rect_ex;
    logic [WID_W-1:0]     rect_ey;
    logic [WID_W-1:0]     rect_ex_c;
    logic [WID_W-1:0]     rect_ey_c;
    logic                 rect_abort;
    logic                 rect_empty;
    logic                 pix_in;

    // Window end: start plus span minus one, a zero span counting as one,
    // clipped to limit minus one.
    function automatic logic [COORD_W-1:0] clip_end(
        input logic [COORD_W-1:0] start_pos,
        input logic [COORD_W-1:0] span,
        input logic [WID_W-1:0]   limit
    );
        logic [WID_W-1:0] end_pos;
        logic [WID_W-1:0] lim1;
        begin
            end_pos = (span == '0) ? WID_W'(start_pos)
                                   : WID_W'(start_pos) + WID_W'(span) - WID_W'(1);
            lim1 = limit - WID_W'(1);
            clip_end = (end_pos > lim1) ? lim1[COORD_W-1:0] : end_pos[COORD_W-1:0];
        end
    endfunction

    // Panel size as used: width clamped to 1..MAX_COLUMNS, height rounded down
    // to whole pages and clamped to 8..MAX_ROWS.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (WID_W'(width_reg) > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = WID_W'(width_reg);
        end

        h_floor = HGT_W'({height_reg[PH_W-1:3], 3'b000});
        if (h_floor > ROW_TOP)
        begin
            h_eff = ROW_TOP;
        end
        else if (h_floor < HGT_W'(8))
        begin
            h_eff = HGT_W'(8);
        end
        else
        begin
            h_eff = h_floor;
        end
    end

    assign bidx_ext = CMP_W'(byte_index);

    // The pixel unit works on the cursor for a count fill and on the
    // working position for rectangles and single pixels.
    assign pcol     = (kind_reg == KIND_FILL_COUNT) ? cur_col_reg : wcol_reg;
    assign prow     = (kind_reg == KIND_FILL_COUNT) ? cur_row_reg : wrow_reg;
    assign in_panel = (WID_W'(pcol) < w_eff) && (prow < h_eff);
    assign idx_full = MUL_W'(w_eff) * MUL_W'(prow[COORD_W-1:3]) + MUL_W'(pcol);
    assign bit_mask = DATA_W'(1) << bit_reg;

    // Rectangle clipping, worked out while the command is taken.
    assign rect_ex    = WID_W'(pos_x) + WID_W'(span_w);
    assign rect_ey    = WID_W'(pos_y) + WID_W'(span_h);
    assign rect_abort = ((rect_ex > w_eff) && (WID_W'(pos_x) > w_eff))
                     || ((rect_ey > WID_W'(h_eff)) && (WID_W'(pos_y) > WID_W'(h_eff)));
    assign rect_ex_c  = (rect_ex > w_eff) ? w_eff : rect_ex;
    assign rect_ey_c  = (rect_ey > WID_W'(h_eff)) ? WID_W'(h_eff) : rect_ey;
    assign rect_empty = (WID_W'(pos_x) >= rect_ex_c) || (WID_W'(pos_y) >= rect_ey_c);
    assign pix_in     = (WID_W'(pos_x) < w_eff) && (pos_y < h_eff);

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        win_left_next   = win_left_reg;
        win_top_next    = win_top_reg;
        win_right_next  = win_right_reg;
        win_bottom_next = win_bottom_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        draw_cnt_next   = draw_cnt_reg;
        done_next       = 1'b0;
        rd_out_next     = '0;
        addr_next       = addr_reg;
        kind_next       = kind_reg;
        colour_next     = colour_reg;
        count_next      = count_reg;
        wcol_next       = wcol_reg;
        wrow_next       = wrow_reg;
        rx0_next        = rx0_reg;
        rex_next        = rex_reg;
        rey_next        = rey_reg;
        bit_next        = bit_reg;
        rd_ok_next      = rd_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        ram_raddr       = addr_reg;

        // Configuration writes are taken in every state.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:  width_next  = cfg_data[PW_W-1:0];
                REG_PANEL_HEIGHT: height_next = cfg_data[PH_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                ram_raddr = bidx_ext[AW-1:0];
                if (start)
                begin
                    kind_next   = kind;
                    colour_next = colour;
                    case (kind)
                        KIND_SET_WINDOW:
                        begin
                            win_left_next   = pos_x;
                            win_top_next    = pos_y;
                            win_right_next  = clip_end(pos_x, span_w, w_eff);
                            win_bottom_next = clip_end(pos_y, span_h, WID_W'(h_eff));
                            cur_col_next    = pos_x;
                            cur_row_next    = pos_y;
                            done_next       = 1'b1;
                        end
                        KIND_SET_START:
                        begin
                            win_left_next = pos_x;
                            win_top_next  = pos_y;
                            cur_col_next  = pos_x;
                            cur_row_next  = pos_y;
                            done_next     = 1'b1;
                        end
                        KIND_FILL_COUNT:
                        begin
                            count_next = pixel_count;
                            if (pixel_count == '0)
                            begin
                                draw_cnt_next = draw_cnt_reg + UCNT_W'(1);
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ADDR;
                            end
                        end
                        KIND_FILL_RECT:
                        begin
                            wcol_next = pos_x;
                            wrow_next = pos_y;
                            rx0_next  = pos_x;
                            rex_next  = rect_ex_c;
                            rey_next  = rect_ey_c;
                            if (rect_abort)
                            begin
                                done_next = 1'b1;
                            end
                            else if (rect_empty)
                            begin
                                draw_cnt_next = draw_cnt_reg + UCNT_W'(1);
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ADDR;
                            end
                        end
                        KIND_PIXEL:
                        begin
                            wcol_next = pos_x;
                            wrow_next = pos_y;
                            if (pix_in)
                            begin
                                state_next = S_ADDR;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        KIND_READ_BYTE:
                        begin
                            rd_ok_next = (bidx_ext < CMP_W'(DEPTH));
                            state_next = S_RDWAIT;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                rd_out_next = rd_ok_reg ? ram_rdata : '0;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_ADDR:
            begin
                addr_next = idx_full[AW-1:0];
                bit_next  = prow[2:0];
                state_next = in_panel ? S_READ : S_STEP;
            end

            S_READ:
            begin
                ram_raddr  = addr_reg;
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = colour_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
                state_next = S_STEP;
            end

            S_STEP:
            begin
                case (kind_reg)
                    KIND_FILL_COUNT:
                    begin
                        if (WID_W'(cur_col_reg) + WID_W'(1) > WID_W'(win_right_reg))
                        begin
                            cur_col_next = win_left_reg;
                            if (WID_W'(cur_row_reg) + WID_W'(1) > WID_W'(win_bottom_reg))
                            begin
                                cur_row_next = win_top_reg;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + COORD_W'(1);
                            end
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + COORD_W'(1);
                        end
                        count_next = count_reg - COUNT_W'(1);
                        if (count_reg == COUNT_W'(1))
                        begin
                            draw_cnt_next = draw_cnt_reg + UCNT_W'(1);
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_ADDR;
                        end
                    end
                    KIND_FILL_RECT:
                    begin
                        if (WID_W'(wcol_reg) + WID_W'(1) < rex_reg)
                        begin
                            wcol_next  = wcol_reg + COORD_W'(1);
                            state_next = S_ADDR;
                        end
                        else if (WID_W'(wrow_reg) + WID_W'(1) < rey_reg)
                        begin
                            wcol_next  = rx0_reg;
                            wrow_next  = wrow_reg + COORD_W'(1);
                            state_next = S_ADDR;
                        end
                        else
                        begin
                            draw_cnt_next = draw_cnt_reg + UCNT_W'(1);
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        draw_cnt_next = draw_cnt_reg + UCNT_W'(1);
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            width_reg      <= RESET_PANEL_WIDTH;
            height_reg     <= RESET_PANEL_HEIGHT;
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_right_reg  <= '0;
            win_bottom_reg <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            draw_cnt_reg   <= '0;
            done_reg       <= 1'b0;
            rd_out_reg     <= '0;
            addr_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            win_left_reg   <= win_left_next;
            win_top_reg    <= win_top_next;
            win_right_reg  <= win_right_next;
            win_bottom_reg <= win_bottom_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            draw_cnt_reg   <= draw_cnt_next;
            done_reg       <= done_next;
            rd_out_reg     <= rd_out_next;
            addr_reg       <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        colour_reg <= colour_next;
        count_reg  <= count_next;
        wcol_reg   <= wcol_next;
        wrow_reg   <= wrow_next;
        rx0_reg    <= rx0_next;
        rex_reg    <= rex_next;
        rey_reg    <= rey_next;
        bit_reg    <= bit_next;
        rd_ok_reg  <= rd_ok_next;
    end

    // The frame store: one byte per column of each eight-row page.
    mpfd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign read_data    = rd_out_reg;
    assign update_count = draw_cnt_reg;

    // The update counter only moves together with a result strobe.
    a_cnt_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (draw_cnt_reg != $past(draw_cnt_reg)) |-> done_reg)
        else $error("update counter moved without a result");

    // When it moves, it moves by exactly one.
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (draw_cnt_reg != $past(draw_cnt_reg))
            |-> (draw_cnt_reg == $past(draw_cnt_reg) + UCNT_W'(1)))
        else $error("update counter skipped");

    // Read data is zero outside a result cycle.
    a_rd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_out_reg != '0) |-> done_reg)
        else $error("read data set outside a result");

    // A pixel inside the panel always addresses a byte inside the store.
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ADDR) && in_panel) |-> (idx_full < MUL_W'(DEPTH)))
        else $error("pixel address beyond the frame store");

    // No result is produced while the store is being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !done_reg)
        else $error("result during the clearing pass");

endmodule
